// File: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// shared types and constants of the checksummed frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  // opcodes of the request word
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  // kind of a response word
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // frame status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_SUM   = 2'd1;
  localparam status_t ST_TOO_LONG  = 2'd2;
  localparam status_t ST_TOO_SHORT = 2'd3;

  // configuration register indexes
  localparam logic CFG_SYNC_BYTE  = 1'b0;
  localparam logic CFG_REPLY_TYPE = 1'b1;

  // register reset values
  localparam logic [7:0] SYNC_BYTE_RESET  = 8'hAA;
  localparam logic [7:0] REPLY_TYPE_RESET = 8'h02;

  // frame layout
  localparam int unsigned HDR_BYTES   = 3;   // sync plus two length bytes
  localparam int unsigned MIN_LEN     = 5;   // shortest length holding the package number
  localparam int unsigned TYPE_OFFSET = 4;   // reply type position
  localparam int unsigned PKG_HI_OFF  = 5;
  localparam int unsigned PKG_LO_OFF  = 6;
  localparam int unsigned PAGE_BITS   = 8;   // 256 byte flash pages
  localparam int unsigned SECTOR_BITS = 4;   // 16 pages to an erase sector

  // source of read data
  typedef logic [1:0] rd_src_t;
  localparam rd_src_t RD_ZERO  = 2'd0;
  localparam rd_src_t RD_RAM   = 2'd1;
  localparam rd_src_t RD_PATCH = 2'd2;

  typedef struct packed {
    logic          kind;
    status_t       status;
    logic [15:0]   package_number;
    logic [7:0]    reply_checksum;
    logic [9:0]    frame_bytes;
    rd_src_t       rd_src;
    logic [7:0]    rd_patch;
  } cfr_result_t;

endpackage

`default_nettype wire

// File: rtl/cfr_if.sv
// ----------------------------------------------------------------------------
// cfr_in_if / cfr_out_if
// valid/ready channels of the frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  logic [8:0] read_index;

  modport source (output valid, opcode, rx_byte, read_index, input ready);
  modport sink   (input valid, opcode, rx_byte, read_index, output ready);
endinterface

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [15:0] package_number;
  logic [23:0] flash_address;
  logic        erase_sector;
  logic [7:0]  reply_checksum;
  logic [9:0]  frame_bytes;
  logic [7:0]  read_data;

  modport source (output valid, kind, status, package_number, flash_address, erase_sector,
                  reply_checksum, frame_bytes, read_data, input ready);
  modport sink   (input valid, kind, status, package_number, flash_address, erase_sector,
                  reply_checksum, frame_bytes, read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/checksummed_frame_receiver.sv
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// assembles sync/length/payload/checksum frames from received bytes and
// reports each frame, and returns stored buffer bytes on request
// ----------------------------------------------------------------------------
//
//   channel   role   word                                  handshake
//   req       sink   opcode, rx_byte, read_index           valid/ready
//   rsp       source kind, status, package_number, ...     valid/ready
//   cfg_*     sink   register index and data               write enable only
//
// one word is taken every cycle while rsp is not stalled; a word passes the
// input register, then the result register with the buffer read beside it
// rst is synchronous and clears frame state and registers; no word is taken
// while rst is high; buffer contents are left as they are; the user must read
// back only written entries, which the block itself does not enforce
// a stalled rsp holds the result register and the buffer read data, the
// input register takes a word only while it is empty or the result stage has room
//
`default_nettype none

module checksummed_frame_receiver #(
  parameter int BUFFER_DEPTH = 512
) (
  input  wire logic       clk,
  input  wire logic       rst,
  cfr_in_if.sink          req,
  cfr_out_if.source       rsp,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);
  import cfr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  // configuration registers
  logic [7:0] sync_byte;
  logic [7:0] reply_type;

  // input register
  logic       s1_valid;
  logic       s1_opcode;
  logic [7:0] s1_rx_byte;
  logic [8:0] s1_read_index;

  // result register
  logic        s2_valid;
  cfr_result_t s2_res;

  logic          advance;
  logic          step;
  logic          res_valid;
  cfr_result_t   res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= SYNC_BYTE_RESET;
      reply_type <= REPLY_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE:  sync_byte  <= cfg_data;
        CFG_REPLY_TYPE: reply_type <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // the result stage moves whenever it is empty or being drained
  assign advance   = !s2_valid || rsp.ready;
  assign req.ready = !rst && (!s1_valid || advance);
  assign step      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_opcode     <= req.opcode;
      s1_rx_byte    <= req.rx_byte;
      s1_read_index <= req.read_index;
    end
  end

  cfr_parser #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .opcode     (s1_opcode),
    .rx_byte    (s1_rx_byte),
    .read_index (s1_read_index),
    .sync_byte  (sync_byte),
    .reply_type (reply_type),
    .res_valid  (res_valid),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr)
  );

  // frame buffer; read issued with the word, data lines up with the result
  cfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buffer (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_res <= res;
    end
  end

  // response word
  always_comb begin
    rsp.valid          = s2_valid;
    rsp.kind           = s2_res.kind;
    rsp.status         = s2_res.status;
    rsp.package_number = s2_res.package_number;
    rsp.flash_address  = {s2_res.package_number, PAGE_BITS'(0)};
    // only a good frame report carries the erase flag
    rsp.erase_sector   = (s2_res.kind == KIND_REPORT) && (s2_res.status == ST_OK) &&
                         (s2_res.package_number[SECTOR_BITS-1:0] == '0);
    rsp.reply_checksum = s2_res.reply_checksum;
    rsp.frame_bytes    = s2_res.frame_bytes;
    case (s2_res.rd_src)
      RD_RAM:   rsp.read_data = ram_rdata;
      RD_PATCH: rsp.read_data = s2_res.rd_patch;
      default:  rsp.read_data = 8'h00;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfr_parser.sv
// ----------------------------------------------------------------------------
// cfr_parser
// frame state, running checksum and report logic, one word a cycle while step is high
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_parser #(
  parameter int BUFFER_DEPTH = 512
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic                            opcode,
  input  wire logic [7:0]                      rx_byte,
  input  wire logic [8:0]                      read_index,
  input  wire logic [7:0]                      sync_byte,
  input  wire logic [7:0]                      reply_type,
  output logic                                 res_valid,
  output cfr_pkg::cfr_result_t                 res,
  output logic                                 ram_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                           ram_wdata,
  output logic [$clog2(BUFFER_DEPTH)-1:0]      ram_raddr
);
  import cfr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [16:0] MAX_LEN = 17'(BUFFER_DEPTH - HDR_BYTES);

  logic          in_frame;
  logic [PW-1:0] pos;
  logic [15:0]   length_field;
  logic [7:0]    running_sum;
  logic [7:0]    len_hi;
  logic [7:0]    byte4;
  logic [7:0]    byte5;
  logic [7:0]    byte6;
  logic          patch_valid;
  logic [7:0]    patch_data;

  logic          hunt;
  logic          take;
  logic          sync_hit;
  logic [PW-1:0] pos_inc;
  logic [15:0]   len_now;
  logic [16:0]   total;
  logic          too_long;
  logic          frame_end;
  logic          short_len;
  logic          sum_match;
  logic          ok_end;
  logic [7:0]    rsum;

  always_comb begin
    hunt      = step && (opcode == OP_RECV) && !in_frame;
    take      = step && (opcode == OP_RECV) && in_frame;
    sync_hit  = hunt && (rx_byte == sync_byte);
    pos_inc   = pos + 1'b1;
    len_now   = (pos == PW'(2)) ? {len_hi, rx_byte} : length_field;
    total     = {1'b0, len_now} + 17'(HDR_BYTES);
    // length known at the second length byte
    too_long  = (pos == PW'(2)) && ({1'b0, len_now} > MAX_LEN);
    frame_end = (pos >= PW'(2)) && (17'(pos_inc) == total);
    short_len = len_now < 16'(MIN_LEN);
    sum_match = rx_byte == running_sum;
    ok_end    = take && !too_long && frame_end && !short_len && sum_match;
    rsum      = running_sum - byte4 + reply_type;
  end

  // buffer write: sync byte at offset zero, then every frame byte in place;
  // the checksum slot of a good frame takes the reply checksum
  always_comb begin
    ram_we    = sync_hit || take;
    ram_waddr = hunt ? '0 : pos[AW-1:0];
    ram_wdata = ok_end ? rsum : rx_byte;
    ram_raddr = AW'(read_index);
  end

  always_comb begin
    res            = '0;
    res_valid      = 1'b0;
    if (step && (opcode == OP_READ)) begin
      res_valid = 1'b1;
      res.kind  = KIND_READ;
      if (int'(read_index) >= BUFFER_DEPTH) begin
        res.rd_src = RD_ZERO;
      end else if (patch_valid && (read_index == 9'(TYPE_OFFSET))) begin
        res.rd_src = RD_PATCH;
      end else begin
        res.rd_src = RD_RAM;
      end
      res.rd_patch = patch_data;
    end else if (take && too_long) begin
      res_valid       = 1'b1;
      res.kind        = KIND_REPORT;
      res.status      = ST_TOO_LONG;
      res.frame_bytes = 10'(HDR_BYTES);
    end else if (take && frame_end) begin
      res_valid       = 1'b1;
      res.kind        = KIND_REPORT;
      res.frame_bytes = total[9:0];
      if (short_len) begin
        res.status = ST_TOO_SHORT;
      end else if (!sum_match) begin
        res.status = ST_BAD_SUM;
      end else begin
        res.status         = ST_OK;
        res.package_number = {byte5, byte6};
        res.reply_checksum = rsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      pos          <= '0;
      length_field <= '0;
      running_sum  <= '0;
      patch_valid  <= 1'b0;
    end else begin
      if (sync_hit) begin
        in_frame    <= 1'b1;
        pos         <= PW'(1);
        running_sum <= '0;
      end else if (take) begin
        if (pos == PW'(2)) begin
          length_field <= len_now;
        end
        if (too_long || frame_end) begin
          in_frame    <= 1'b0;
          pos         <= '0;
          running_sum <= '0;
        end else begin
          pos         <= pos_inc;
          running_sum <= running_sum + rx_byte;
        end
      end
      // reply type overlays offset four until a new frame writes that slot
      if (ok_end) begin
        patch_valid <= 1'b1;
      end else if (take && (pos == PW'(TYPE_OFFSET))) begin
        patch_valid <= 1'b0;
      end
    end
  end

  // header bytes kept aside for the report
  always_ff @(posedge clk) begin
    if (take) begin
      if (pos == PW'(1)) begin
        len_hi <= rx_byte;
      end
      if (pos == PW'(TYPE_OFFSET)) begin
        byte4 <= rx_byte;
      end
      if (pos == PW'(PKG_HI_OFF)) begin
        byte5 <= rx_byte;
      end
      if (pos == PW'(PKG_LO_OFF)) begin
        byte6 <= rx_byte;
      end
    end
    if (ok_end) begin
      patch_data <= reply_type;
    end
  end

endmodule

`default_nettype wire

// File: tb/checksummed_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_tb
// drives request words into the frame receiver and checks every response
// word against a frame tracker that follows sync, length, payload and
// checksum byte by byte, then reports status, package fields and read data
// ----------------------------------------------------------------------------

module checksummed_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int unsigned BUF_DEPTH      = 512;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned SQUEEZE_AFTER  = 300;  // useful words before the long hold-off
  localparam int unsigned MAX_PRINTED    = 40;

  // one response word, as the tracker predicts it
  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [15:0] package_number;
    logic [23:0] flash_address;
    logic        erase_sector;
    logic [7:0]  reply_checksum;
    logic [9:0]  frame_bytes;
    logic [7:0]  read_data;
  } frame_reply_t;

  // ways a frame can be spoiled on purpose
  typedef enum int {FLAW_NONE, FLAW_BAD_SUM, FLAW_CUT} frame_flaw_t;

  // follows the receive state and the buffer, queues the replies it expects
  class frame_tracker;
    logic [7:0]   sync_byte;
    logic [7:0]   reply_type;
    bit           in_frame;
    int unsigned  position;
    int unsigned  length;
    logic [7:0]   running_sum;
    logic [7:0]   frame_store [BUF_DEPTH];
    bit           written [BUF_DEPTH];
    int unsigned  written_list [$];
    frame_reply_t awaited [$];
    int unsigned  useful_words;
    int unsigned  errors;

    function new();
      sync_byte    = SYNC_BYTE_RESET;
      reply_type   = REPLY_TYPE_RESET;
      in_frame     = 0;
      position     = 0;
      length       = 0;
      running_sum  = '0;
      useful_words = 0;
      errors       = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_register(logic index, logic [7:0] value);
      if (index == CFG_SYNC_BYTE) sync_byte = value;
      else reply_type = value;
    endfunction

    function void store_byte(int unsigned at, logic [7:0] value);
      frame_store[at] = value;
      if (!written[at]) begin
        written[at] = 1;
        written_list.push_back(at);
      end
    endfunction

    function logic [8:0] pick_stored();
      return 9'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    // called once per accepted request word
    function void track_request(logic op, logic [7:0] b, logic [8:0] idx);
      frame_reply_t r;
      int unsigned total;
      logic [15:0] pkg;
      logic [7:0] rsum;
      r = '0;
      if (op == OP_READ) begin
        useful_words++;
        r.kind = KIND_READ;
        r.read_data = frame_store[idx];
        awaited.push_back(r);
        return;
      end
      if (!in_frame) begin
        // bytes between frames are dropped unless they match the sync byte
        if (b == sync_byte) begin
          useful_words++;
          store_byte(0, b);
          position    = 1;
          running_sum = '0;
          in_frame    = 1;
        end
        return;
      end
      useful_words++;
      if (position < BUF_DEPTH) store_byte(position, b);
      position++;
      r.kind = KIND_REPORT;
      if (position == HDR_BYTES) begin
        length = {frame_store[1], frame_store[2]};
        if (length + HDR_BYTES > BUF_DEPTH) begin
          r.status      = ST_TOO_LONG;
          r.frame_bytes = 10'(HDR_BYTES);
          awaited.push_back(r);
          in_frame    = 0;
          position    = 0;
          running_sum = '0;
          return;
        end
      end
      total = length + HDR_BYTES;
      if (position >= HDR_BYTES && position == total) begin
        r.frame_bytes = 10'(total);
        if (length < MIN_LEN) begin
          r.status = ST_TOO_SHORT;
        end else if (b != running_sum) begin
          r.status = ST_BAD_SUM;
        end else begin
          // the buffer turns into the reply frame: new type byte, new checksum
          pkg  = {frame_store[PKG_HI_OFF], frame_store[PKG_LO_OFF]};
          rsum = running_sum - frame_store[TYPE_OFFSET] + reply_type;
          frame_store[TYPE_OFFSET] = reply_type;
          frame_store[position - 1] = rsum;
          r.status         = ST_OK;
          r.package_number = pkg;
          r.flash_address  = {8'h00, pkg} << PAGE_BITS;
          r.erase_sector   = (pkg[SECTOR_BITS-1:0] == '0);
          r.reply_checksum = rsum;
        end
        awaited.push_back(r);
        in_frame    = 0;
        position    = 0;
        running_sum = '0;
        return;
      end
      running_sum = running_sum + b;
    endfunction

    task report(string what);
      if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_response(frame_reply_t got);
      frame_reply_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word, kind %0h status %0h", got.kind, got.status));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0h, expected %0h", got.kind, want.kind));
      if (got.status !== want.status)
        report($sformatf("status %0h, expected %0h", got.status, want.status));
      if (got.package_number !== want.package_number)
        report($sformatf("package_number %0h, expected %0h",
                         got.package_number, want.package_number));
      if (got.flash_address !== want.flash_address)
        report($sformatf("flash_address %0h, expected %0h",
                         got.flash_address, want.flash_address));
      if (got.erase_sector !== want.erase_sector)
        report($sformatf("erase_sector %0h, expected %0h",
                         got.erase_sector, want.erase_sector));
      if (got.reply_checksum !== want.reply_checksum)
        report($sformatf("reply_checksum %0h, expected %0h",
                         got.reply_checksum, want.reply_checksum));
      if (got.frame_bytes !== want.frame_bytes)
        report($sformatf("frame_bytes %0d, expected %0d", got.frame_bytes, want.frame_bytes));
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %0h, expected %0h", got.read_data, want.read_data));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  cfr_in_if  req_ch ();
  cfr_out_if rsp_ch ();

  checksummed_frame_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_tracker sb;

  // knobs of the sender; quiet_tail is also read by the receiver
  int unsigned gap_odds   = 0;  // percent chance of an idle burst before a word
  int unsigned read_odds  = 0;  // percent chance of a read slipped in after a frame byte
  bit          quiet_tail = 0;  // no idling at all in the last part of the run
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, sb.awaited.size());
      $display("checksummed_frame_receiver_tb: FAIL");
      $finish;
    end
  end

  // present one request word at the falling edge and hold it until taken
  task automatic issue_word(input logic op, input logic [7:0] b, input logic [8:0] idx);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 99) < gap_odds) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.opcode     = op;
    req_ch.rx_byte    = b;
    req_ch.read_index = idx;
    do @(posedge clk); while (!req_ch.ready);
    // the tracker is updated here, so later picks of stored entries see this word
    sb.track_request(op, b, idx);
  endtask

  // sync, big-endian length, payload, checksum; fill >= 0 gives a fixed payload
  task automatic send_frame(input int unsigned len, input frame_flaw_t flaw,
                            input int fill = -1);
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [15:0] len_field;
    int unsigned total;
    int unsigned cut_at;
    len_field = 16'(len);
    total     = len + HDR_BYTES;
    // an oversized length is dropped after the header, nothing more to send
    if (total > BUF_DEPTH) total = HDR_BYTES;
    cut_at = (flaw == FLAW_CUT) ? $urandom_range(1, total - 1) : total;
    sum = '0;
    for (int unsigned i = 0; i < cut_at; i++) begin
      if (i == 0) b = sb.sync_byte;
      else if (i == 1) b = len_field[15:8];
      else if (i == 2) b = len_field[7:0];
      else if (i == total - 1) b = (flaw == FLAW_BAD_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
      else if (fill >= 0) b = 8'(fill);
      // low package byte often on a sector boundary so the erase flag shows up
      else if (i == PKG_LO_OFF && $urandom_range(0, 2) == 0) b = {4'($urandom), 4'h0};
      else b = 8'($urandom);
      if (i > 0) sum = sum + b;
      issue_word(OP_RECV, b, 9'($urandom));
      if (sb.written_list.size() != 0 && $urandom_range(0, 99) < read_odds)
        issue_word(OP_READ, 8'($urandom), sb.pick_stored());
    end
  endtask

  function automatic int unsigned pick_length();
    if ($urandom_range(0, 99) < 3) return $urandom_range(25, 300);
    return $urandom_range(MIN_LEN, 24);
  endfunction

  // drain everything in flight, let the pipeline empty, then write both registers
  task automatic reconfigure(input logic [7:0] sync_val, input logic [7:0] reply_val);
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    // words with no result may still be inside the two-stage pipe
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_SYNC_BYTE;
    cfg_data  = sync_val;
    sb.set_register(CFG_SYNC_BYTE, sync_val);
    @(negedge clk);
    cfg_index = CFG_REPLY_TYPE;
    cfg_data  = reply_val;
    sb.set_register(CFG_REPLY_TYPE, reply_val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly good frames with random content, some spoiled ones, noise and reads
  task automatic run_phase(input int unsigned target);
    int unsigned roll;
    while (sb.useful_words < target) begin
      // pick at random between bursty and gap-free stretches on the send side
      gap_odds = $urandom_range(0, 1) ? 0 : 30;
      roll = $urandom_range(0, 99);
      if (roll < 70) send_frame(pick_length(), FLAW_NONE);
      else if (roll < 80) send_frame(pick_length(), FLAW_BAD_SUM);
      else if (roll < 85) send_frame($urandom_range(0, MIN_LEN - 1), FLAW_NONE);
      else if (roll < 89) send_frame($urandom_range(BUF_DEPTH - HDR_BYTES + 1, 16'hFFFF), FLAW_NONE);
      else if (roll < 93) send_frame(pick_length(), FLAW_CUT);
      else repeat ($urandom_range(1, 4)) issue_word(OP_RECV, 8'($urandom), 9'($urandom));
      if (sb.written_list.size() != 0)
        repeat ($urandom_range(0, 3)) issue_word(OP_READ, 8'($urandom), sb.pick_stored());
    end
    // no half-received frame may straddle a settings change
    while (sb.in_frame) issue_word(OP_RECV, 8'($urandom), 9'($urandom));
  endtask

  // response side: random hold-offs, one long squeeze, checks on every taken word
  initial begin : drain
    int unsigned  hold_left;
    int unsigned  mode_left;
    bit           choppy;
    bit           squeezed;
    frame_reply_t got;
    hold_left = 0;
    mode_left = 0;
    choppy    = 0;
    squeezed  = 0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (mode_left == 0) begin
        choppy    = $urandom_range(0, 1);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (!squeezed && sb.useful_words >= SQUEEZE_AFTER) begin
        // long stall while the sender keeps going, so the block backs up
        squeezed  = 1;
        hold_left = SQUEEZE_CYCLES;
      end else if (hold_left == 0 && choppy && !quiet_tail && $urandom_range(0, 3) == 0) begin
        hold_left = $urandom_range(1, 9);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.kind           = rsp_ch.kind;
        got.status         = rsp_ch.status;
        got.package_number = rsp_ch.package_number;
        got.flash_address  = rsp_ch.flash_address;
        got.erase_sector   = rsp_ch.erase_sector;
        got.reply_checksum = rsp_ch.reply_checksum;
        got.frame_bytes    = rsp_ch.frame_bytes;
        got.read_data      = rsp_ch.read_data;
        sb.check_response(got);
      end
      @(negedge clk);
    end
  end

  // request side and run control
  initial begin : stimulus
    sb = new();
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SYNC_BYTE;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_RECV;
    req_ch.rx_byte    = '0;
    req_ch.read_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, extremes and each kind of report
    gap_odds = 20;
    issue_word(OP_RECV, 8'h00, 9'h1FF);          // noise between frames
    issue_word(OP_RECV, 8'hFF, 9'h000);
    send_frame(0, FLAW_NONE);                    // zero length, too short at the header
    send_frame(16'hFFFF, FLAW_NONE);             // largest length, too long
    send_frame(MIN_LEN, FLAW_NONE, 8'hFF);       // good frame, package 0xffff
    send_frame(MIN_LEN, FLAW_BAD_SUM, 8'h00);    // checksum off, package fields stay zero
    issue_word(OP_READ, 8'hFF, 9'd0);
    issue_word(OP_READ, 8'h00, 9'(TYPE_OFFSET)); // type byte overwritten by the bad-sum frame

    // random phases, each under its own register settings
    read_odds = 4;
    reconfigure(8'h00, 8'hFF);
    // one frame filling the whole buffer so reads reach the top entries
    send_frame(BUF_DEPTH - HDR_BYTES, FLAW_NONE);
    issue_word(OP_READ, 8'($urandom), 9'(BUF_DEPTH - 1));
    run_phase(600);
    reconfigure(8'hFF, 8'h00);
    run_phase(950);
    reconfigure(8'($urandom), 8'($urandom));
    run_phase(1300);
    reconfigure(SYNC_BYTE_RESET, REPLY_TYPE_RESET);
    quiet_tail = 1;
    run_phase(1550);

    // let every expected word come out, then wait on for strays
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("checksummed_frame_receiver_tb: PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("checksummed_frame_receiver_tb: FAIL");
    end
    $finish;
  end

endmodule
